[src/miq_pkg.sv]
package miq_pkg;

  // Request codes carried on the input channel.
  typedef enum logic [1:0] {
    REQ_PUSH_BACK = 2'd0,
    REQ_PUSH_MID  = 2'd1,
    REQ_POP       = 2'd2,
    REQ_NONE      = 2'd3
  } req_e;

  // Status codes carried on the output channel.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_POP_DATA = 4'b0010,
    ST_MV_RD    = 4'b0100,
    ST_MV_WR    = 4'b1000
  } state_e;

  // Fixed widths of the channel fields.
  localparam int unsigned REQ_W = 2;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned STAT_W = 2;

endpackage

[src/middle_insert_queue.sv]
// Channel   Handshake                   Payload
// input     in_valid_i / in_stall_o     req_type_i, value_i
// output    out_valid_o / out_stall_i   value_res_o, status_o
//
// A push writes at once; a push at the back then reads and writes again when
// an entry moves to the front half. A pop reads, returns the entry and may then
// make that move; its result passes a pending register to the output register.
// Each half is a single-port memory; one shared ring-index adder serves both.
// Reset clears heads, counts and handshake state; the memories are not cleared.
// A request is taken only while the sequencer is idle and no result waits to
// enter the output register, which holds its result while out_stall_i is high.
module middle_insert_queue #(
  parameter int unsigned HALF_DEPTH = 512,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [miq_pkg::REQ_W-1:0]   req_type_i,
  input  logic [miq_pkg::VAL_W-1:0]   value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [miq_pkg::VAL_W-1:0]   value_res_o,
  output logic [miq_pkg::STAT_W-1:0]  status_o
);
  import miq_pkg::*;

  localparam int unsigned AW = $clog2(HALF_DEPTH);
  localparam int unsigned CW = $clog2(HALF_DEPTH + 1);

  logic                  accept;
  logic                  seq_idle;
  logic [DATA_WIDTH-1:0] req_value;
  logic                  res_valid;
  logic [DATA_WIDTH-1:0] res_data;
  status_e               res_status;
  logic [VAL_W-1:0]      res_value;

  logic                  f_we;
  logic [AW-1:0]         f_addr;
  logic [DATA_WIDTH-1:0] f_wdata;
  logic [DATA_WIDTH-1:0] f_rdata;
  logic                  b_we;
  logic [AW-1:0]         b_addr;
  logic [DATA_WIDTH-1:0] b_wdata;
  logic [DATA_WIDTH-1:0] b_rdata;

  logic                  pend_q, pend_d;
  logic [VAL_W-1:0]      pend_value_q;
  status_e               pend_status_q;
  logic                  out_valid_q, out_valid_d;
  logic [VAL_W-1:0]      out_value_q;
  status_e               out_status_q;
  logic                  load_out;

  // Fit the entry to the storage width and the result back to the field.
  if (DATA_WIDTH <= VAL_W) begin : g_narrow
    assign req_value = value_i[DATA_WIDTH-1:0];
    assign res_value = VAL_W'(res_data);
  end else begin : g_wide
    assign req_value = {{(DATA_WIDTH - VAL_W){value_i[VAL_W-1]}}, value_i};
    assign res_value = res_data[VAL_W-1:0];
  end

  assign in_stall_o = !seq_idle || pend_q;
  assign accept     = in_valid_i && !in_stall_o;

  miq_seq #(
    .HALF_DEPTH(HALF_DEPTH),
    .DATA_WIDTH(DATA_WIDTH),
    .AW        (AW),
    .CW        (CW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (accept),
    .req_type_i  (req_type_i),
    .req_value_i (req_value),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .res_status_o(res_status),
    .f_we_o      (f_we),
    .f_addr_o    (f_addr),
    .f_wdata_o   (f_wdata),
    .f_rdata_i   (f_rdata),
    .b_we_o      (b_we),
    .b_addr_o    (b_addr),
    .b_wdata_o   (b_wdata),
    .b_rdata_i   (b_rdata)
  );

  miq_ring #(
    .DEPTH(HALF_DEPTH),
    .WIDTH(DATA_WIDTH),
    .AW   (AW)
  ) u_front (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .addr_i (f_addr),
    .wdata_i(f_wdata),
    .rdata_o(f_rdata)
  );

  miq_ring #(
    .DEPTH(HALF_DEPTH),
    .WIDTH(DATA_WIDTH),
    .AW   (AW)
  ) u_back (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .addr_i (b_addr),
    .wdata_i(b_wdata),
    .rdata_o(b_rdata)
  );

  // A pending result moves to the output register once that is free.
  assign load_out = pend_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    pend_d = pend_q;
    if (res_valid) begin
      pend_d = 1'b1;
    end else if (load_out) begin
      pend_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Handshake state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      pend_value_q  <= res_value;
      pend_status_q <= res_status;
    end
    if (load_out) begin
      out_value_q  <= pend_value_q;
      out_status_q <= pend_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_res_o = out_value_q;
  assign status_o    = out_status_q;

endmodule

[src/miq_ring.sv]
module miq_ring #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port: a write, or a registered read, each cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/miq_idx.sv]
module miq_idx #(
  parameter int unsigned HALF_DEPTH = 512,
  parameter int unsigned AW         = 9,
  parameter int unsigned CW         = 10
) (
  input  logic [AW-1:0] base_i,
  input  logic [CW-1:0] off_i,
  output logic [AW-1:0] idx_o
);

  localparam logic [CW:0] WRAP = (CW+1)'(HALF_DEPTH);

  logic [CW:0] sum;
  logic [CW:0] wrapped;

  // Ring index: base plus offset, folded back once into the ring.
  always_comb begin
    sum = (CW+1)'(base_i) + (CW+1)'(off_i);
    if (sum >= WRAP) begin
      wrapped = sum - WRAP;
    end else begin
      wrapped = sum;
    end
  end

  assign idx_o = wrapped[AW-1:0];

endmodule

[src/miq_seq.sv]
module miq_seq #(
  parameter int unsigned HALF_DEPTH = 512,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AW         = 9,
  parameter int unsigned CW         = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic [miq_pkg::REQ_W-1:0] req_type_i,
  input  logic [DATA_WIDTH-1:0] req_value_i,
  output logic                  idle_o,
  output logic                  res_valid_o,
  output logic [DATA_WIDTH-1:0] res_data_o,
  output miq_pkg::status_e      res_status_o,
  output logic                  f_we_o,
  output logic [AW-1:0]         f_addr_o,
  output logic [DATA_WIDTH-1:0] f_wdata_o,
  input  logic [DATA_WIDTH-1:0] f_rdata_i,
  output logic                  b_we_o,
  output logic [AW-1:0]         b_addr_o,
  output logic [DATA_WIDTH-1:0] b_wdata_o,
  input  logic [DATA_WIDTH-1:0] b_rdata_i
);
  import miq_pkg::*;

  localparam logic [CW:0]   FULL_CNT = (CW+1)'(2 * HALF_DEPTH);
  localparam logic [CW-1:0] OFF_ONE  = CW'(1);
  localparam logic [CW-1:0] OFF_PREV = CW'(HALF_DEPTH - 1);

  state_e        state_q, state_d;
  logic [AW-1:0] front_head_q, front_head_d;
  logic [AW-1:0] back_head_q, back_head_d;
  logic [CW-1:0] front_count_q, front_count_d;
  logic [CW-1:0] back_count_q, back_count_d;

  logic [AW-1:0] idx_base;
  logic [CW-1:0] idx_off;
  logic [AW-1:0] idx_res;
  logic [CW:0]   total;
  logic          full;

  // Shared ring-index unit, one index per cycle.
  miq_idx #(
    .HALF_DEPTH(HALF_DEPTH),
    .AW        (AW),
    .CW        (CW)
  ) u_idx (
    .base_i(idx_base),
    .off_i (idx_off),
    .idx_o (idx_res)
  );

  assign total  = (CW+1)'(front_count_q) + (CW+1)'(back_count_q);
  assign full   = (total >= FULL_CNT);
  assign idle_o = (state_q == ST_IDLE);

  // Request sequencer: decode in idle, then read, move and write steps.
  always_comb begin
    state_d       = state_q;
    front_head_d  = front_head_q;
    back_head_d   = back_head_q;
    front_count_d = front_count_q;
    back_count_d  = back_count_q;
    idx_base      = front_head_q;
    idx_off       = front_count_q;
    f_we_o        = 1'b0;
    f_addr_o      = front_head_q;
    f_wdata_o     = req_value_i;
    b_we_o        = 1'b0;
    b_addr_o      = back_head_q;
    b_wdata_o     = req_value_i;
    res_valid_o   = 1'b0;
    res_data_o    = '0;
    res_status_o  = STAT_OK;

    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          unique case (req_e'(req_type_i))
            REQ_POP: begin
              if (total == '0) begin
                res_valid_o  = 1'b1;
                res_status_o = STAT_EMPTY;
              end else begin
                // Read the oldest entry and advance the front head.
                idx_base      = front_head_q;
                idx_off       = OFF_ONE;
                f_addr_o      = front_head_q;
                front_head_d  = idx_res;
                front_count_d = front_count_q - OFF_ONE;
                state_d       = ST_POP_DATA;
              end
            end
            REQ_PUSH_BACK: begin
              if (full) begin
                res_valid_o  = 1'b1;
                res_status_o = STAT_FULL;
              end else begin
                idx_base     = back_head_q;
                idx_off      = back_count_q;
                b_we_o       = 1'b1;
                b_addr_o     = idx_res;
                back_count_d = back_count_q + OFF_ONE;
                if (back_count_q == front_count_q) begin
                  state_d = ST_MV_RD;
                end
              end
            end
            REQ_PUSH_MID: begin
              if (full) begin
                res_valid_o  = 1'b1;
                res_status_o = STAT_FULL;
              end else if (front_count_q > back_count_q) begin
                // The new entry becomes the oldest of the back half.
                idx_base     = back_head_q;
                idx_off      = OFF_PREV;
                back_head_d  = idx_res;
                b_we_o       = 1'b1;
                b_addr_o     = idx_res;
                back_count_d = back_count_q + OFF_ONE;
              end else begin
                idx_base      = front_head_q;
                idx_off       = front_count_q;
                f_we_o        = 1'b1;
                f_addr_o      = idx_res;
                front_count_d = front_count_q + OFF_ONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP_DATA: begin
        res_valid_o = 1'b1;
        res_data_o  = f_rdata_i;
        if (back_count_q > front_count_q) begin
          // Rebalance: start reading the oldest back entry at once.
          idx_base     = back_head_q;
          idx_off      = OFF_ONE;
          b_addr_o     = back_head_q;
          back_head_d  = idx_res;
          back_count_d = back_count_q - OFF_ONE;
          state_d      = ST_MV_WR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MV_RD: begin
        idx_base     = back_head_q;
        idx_off      = OFF_ONE;
        b_addr_o     = back_head_q;
        back_head_d  = idx_res;
        back_count_d = back_count_q - OFF_ONE;
        state_d      = ST_MV_WR;
      end
      ST_MV_WR: begin
        // Append the moved entry to the front half.
        idx_base      = front_head_q;
        idx_off       = front_count_q;
        f_we_o        = 1'b1;
        f_addr_o      = idx_res;
        f_wdata_o     = b_rdata_i;
        front_count_d = front_count_q + OFF_ONE;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      front_head_q  <= '0;
      back_head_q   <= '0;
      front_count_q <= '0;
      back_count_q  <= '0;
    end else begin
      state_q       <= state_d;
      front_head_q  <= front_head_d;
      back_head_q   <= back_head_d;
      front_count_q <= front_count_d;
      back_count_q  <= back_count_d;
    end
  end

endmodule
